// ===== src/wbps_pkg.sv =====
// Package for the wildcard byte pattern search: types, constants and helpers.
`timescale 1ns / 1ps

package wbps_pkg;

  // Pattern and window geometry
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int LEN_W             = 5;
  localparam int WIN_IDX_W         = 4;

  // Queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  // Register indexes (byte address 8*index)
  typedef enum logic [1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_CARE_MASK    = 2'd2,
    REG_PATTERN_LEN  = 2'd3
  } cfg_reg_t;

  // One scanned byte as it travels through the queue
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic        first_of_range;
    logic        last_of_range;
  } item_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // Length in use: zero counts as one, anything above the maximum is clipped
  function automatic logic [LEN_W-1:0] active_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    begin
      res = len;
      if (len == '0) begin
        res = LEN_W'(1);
      end else if (len > LEN_W'(MAX_PATTERN_BYTES)) begin
        res = LEN_W'(MAX_PATTERN_BYTES);
      end
      return res;
    end
  endfunction

endpackage

// ===== src/wildcard_byte_pattern_search_top.sv =====
// Top level: configuration registers, request intake, queue and scan engine.
//
//  channel | direction | handshake          | payload
//  in_     | request   | in_valid/in_ready  | data_byte, byte_address, first/last_of_range
//  out_    | result    | out_valid/out_ready| found, match_address
//  cfg     | APB write | psel/penable/pready| paddr (8 bytes per register), pwdata
//
// One byte is taken per cycle while the queue has room; a byte enters a 4-entry
// queue, and from the queue head the window compare result is registered in the
// result register, from which the receiver takes it.
// While a result waits, the engine holds and later bytes collect in the queue.
// Intake stalls only when the queue is full; the engine stalls only on a
// held result. Reset is synchronous, active low, and clears window and flags.
`timescale 1ns / 1ps

module wildcard_byte_pattern_search_top
  import wbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic [31:0]           in_byte_address,
  input  logic                  in_first_of_range,
  input  logic                  in_last_of_range,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [31:0]           out_match_address,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [63:0]                  pat_low_r, pat_high_r;
  logic [MAX_PATTERN_BYTES-1:0] care_r;
  logic [LEN_W-1:0]             len_r;
  logic                         cfg_wr;
  cfg_reg_t                     cfg_sel;
  item_t                        in_item, head_item;
  q_stat_t                      q_stat;
  logic                         q_push, q_pop;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      care_r     <= '1;
      len_r      <= LEN_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_PATTERN_LOW:  pat_low_r  <= pwdata;
        REG_PATTERN_HIGH: pat_high_r <= pwdata;
        REG_CARE_MASK:    care_r     <= pwdata[MAX_PATTERN_BYTES-1:0];
        REG_PATTERN_LEN:  len_r      <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_sel)
      REG_PATTERN_LOW:  prdata = pat_low_r;
      REG_PATTERN_HIGH: prdata = pat_high_r;
      REG_CARE_MASK:    prdata = CFG_DATA_W'(care_r);
      REG_PATTERN_LEN:  prdata = CFG_DATA_W'(len_r);
      default:          prdata = '0;
    endcase
  end

  // Request intake: accept while the queue has room
  assign in_ready               = !q_stat.full;
  assign q_push                 = in_valid && in_ready;
  assign in_item.data_byte      = in_data_byte;
  assign in_item.byte_address   = in_byte_address;
  assign in_item.first_of_range = in_first_of_range;
  assign in_item.last_of_range  = in_last_of_range;

  wbps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (in_item),
    .pop       (q_pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  wbps_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pattern           ({pat_high_r, pat_low_r}),
    .care_mask         (care_r),
    .pattern_length    (len_r),
    .q_stat            (q_stat),
    .head_item         (head_item),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_match_address (out_match_address)
  );

  // A not-found result always carries a zero address
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_address == '0))
    else $error("not-found result with nonzero address");

  // Intake stalls only when the queue is really full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (q_stat.count == QCNT_W'(QDEPTH)))
    else $error("intake stalled with room in queue");

  // The engine only takes a byte when the result slot can hold its result
  a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_stat.valid && (!out_valid || out_ready)))
    else $error("byte taken while result slot blocked");

endmodule

// ===== src/wbps_queue.sv =====
// Small FIFO that decouples request intake from the scan engine.
`timescale 1ns / 1ps

module wbps_queue
  import wbps_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head_item,
  output q_stat_t stat
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign do_push = push && (count_r != QCNT_W'(QDEPTH));
  assign do_pop  = pop && (count_r != '0);

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item   = mem_r[rd_ptr_r];
  assign stat.valid  = (count_r != '0);
  assign stat.full   = (count_r == QCNT_W'(QDEPTH));
  assign stat.count  = count_r;

endmodule

// ===== src/wbps_back.sv =====
// Scan engine: sliding byte window, masked compare and result register.
`timescale 1ns / 1ps

module wbps_back
  import wbps_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [8*MAX_PATTERN_BYTES-1:0] pattern,
  input  logic [MAX_PATTERN_BYTES-1:0] care_mask,
  input  logic [LEN_W-1:0]             pattern_length,
  input  q_stat_t                      q_stat,
  input  item_t                        head_item,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [31:0]                  out_match_address
);

  logic [7:0]       window_r [MAX_PATTERN_BYTES];
  logic [7:0]       window_nxt [MAX_PATTERN_BYTES];
  logic [7:0]       base [MAX_PATTERN_BYTES];
  logic [LEN_W-1:0] seen_r, seen_nxt, seen_base;
  logic             finished_r, finished_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [31:0]      out_addr_r, out_addr_nxt;
  logic [LEN_W-1:0] len;
  logic             active, matched, hit;
  logic [LEN_W-1:0] pos;

  // Take the queue head once the result slot is free or draining
  assign pop    = q_stat.valid && (!out_valid_r || out_ready);
  assign active = pop && (head_item.first_of_range || !finished_r);
  assign len    = active_len(pattern_length);

  // New window and byte count after this byte
  always_comb begin
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      base[k] = head_item.first_of_range ? 8'd0 : window_r[k];
    end
    window_nxt[0] = head_item.data_byte;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      window_nxt[k] = base[k-1];
    end
    seen_base = head_item.first_of_range ? '0 : seen_r;
    seen_nxt  = (seen_base < LEN_W'(MAX_PATTERN_BYTES)) ? seen_base + LEN_W'(1) : seen_base;
  end

  // Masked compare: pattern byte i against the byte len-1-i places back
  always_comb begin
    matched = 1'b1;
    pos     = '0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      pos = len - LEN_W'(1) - LEN_W'(i);
      if ((LEN_W'(i) < len) && care_mask[i] &&
          (window_nxt[pos[WIN_IDX_W-1:0]] != pattern[8*i +: 8])) begin
        matched = 1'b0;
      end
    end
    hit = matched && (seen_nxt >= len);
  end

  // Finished flag and result register
  always_comb begin
    finished_nxt  = finished_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (active) begin
      finished_nxt = hit || head_item.last_of_range;
      if (hit) begin
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b1;
        out_addr_nxt  = head_item.byte_address - 32'(len - LEN_W'(1));
      end else if (head_item.last_of_range) begin
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b0;
        out_addr_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        window_r[k] <= 8'd0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      finished_r  <= finished_nxt;
      if (active) begin
        seen_r <= seen_nxt;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
          window_r[k] <= window_nxt[k];
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

endmodule
